// ----- hw/rtl/dpc_pkg.sv -----
// dpc_pkg: shared types and codes for the distinct pattern counter
// no dependencies; used by the cell, the channel interfaces and the top level
`default_nettype none

package dpc_pkg;

  // item kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // result status codes
  localparam logic [2:0] ST_MATCH   = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BADIDX  = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // fixed payload widths of the channels
  localparam int KIND_W  = 2;
  localparam int PAT_W   = 32;
  localparam int SEL_W   = 6;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 16;
  localparam int ROWS_W  = 7;

  // control part of the token that walks down the cell chain
  typedef struct packed {
    logic valid;
    op_t  op;
    logic hit;
    logic is_new;
  } tok_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dpc_in_if.sv -----
// dpc_in_if: input channel (valid/ready plus item payload)
// depends on dpc_pkg for payload widths
`default_nettype none

interface dpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [dpc_pkg::KIND_W-1:0]     kind;
  logic [dpc_pkg::PAT_W-1:0]      pattern;
  logic [dpc_pkg::SEL_W-1:0]      row_select;

  modport source (output valid, output kind, output pattern, output row_select,
                  input ready);
  modport sink   (input valid, input kind, input pattern, input row_select,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dpc_out_if.sv -----
// dpc_out_if: result channel (valid/ready plus result payload)
// depends on dpc_pkg for payload widths
`default_nettype none

interface dpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [dpc_pkg::STAT_W-1:0]     status;
  logic [dpc_pkg::SEL_W-1:0]      row_index;
  logic [dpc_pkg::PAT_W-1:0]      pattern_out;
  logic [dpc_pkg::CNT_W-1:0]      occurrences;
  logic [dpc_pkg::ROWS_W-1:0]     rows_in_use;

  modport source (output valid, output status, output row_index, output pattern_out,
                  output occurrences, output rows_in_use, input ready);
  modport sink   (input valid, input status, input row_index, input pattern_out,
                  input occurrences, input rows_in_use, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dpc_cell.sv -----
// dpc_cell: one table row (pattern and count) plus one stage of the token chain
// depends on dpc_pkg for the token control struct and item kinds
`default_nettype none

module dpc_cell #(
  parameter int TABLE_ROWS = 64,
  parameter int CELL_IDX   = 0,
  parameter int SW         = 32,
  parameter int CB         = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [$clog2(TABLE_ROWS+1)-1:0] used_rows,
  input  wire dpc_pkg::tok_ctrl_t        ctrl_i,
  input  wire logic [SW-1:0]             pat_i,
  input  wire logic [dpc_pkg::SEL_W-1:0] sel_i,
  input  wire logic [$clog2(TABLE_ROWS)-1:0] row_i,
  input  wire logic [SW-1:0]             rpat_i,
  input  wire logic [CB-1:0]             rcnt_i,
  output dpc_pkg::tok_ctrl_t             ctrl_o,
  output logic [SW-1:0]                  pat_o,
  output logic [dpc_pkg::SEL_W-1:0]      sel_o,
  output logic [$clog2(TABLE_ROWS)-1:0]  row_o,
  output logic [SW-1:0]                  rpat_o,
  output logic [CB-1:0]                  rcnt_o
);

  localparam int IW    = $clog2(TABLE_ROWS);
  localparam int UW    = $clog2(TABLE_ROWS+1);
  localparam int CMP_W = (UW > dpc_pkg::SEL_W) ? UW : dpc_pkg::SEL_W;
  localparam logic [UW-1:0]    MY_USED = UW'(CELL_IDX);
  localparam logic [CMP_W-1:0] MY_SEL  = CMP_W'(CELL_IDX);
  localparam logic [IW-1:0]    MY_ROW  = IW'(CELL_IDX);

  // stored row
  logic [SW-1:0] pattern_r;
  logic [CB-1:0] count_r;

  // token stage
  dpc_pkg::tok_ctrl_t ctrl_r, ctrl_nxt;
  logic [SW-1:0]                 pat_r;
  logic [dpc_pkg::SEL_W-1:0]     sel_r;
  logic [IW-1:0]                 row_r, row_nxt;
  logic [SW-1:0]                 rpat_r, rpat_nxt;
  logic [CB-1:0]                 rcnt_r, rcnt_nxt;

  logic          row_live;
  logic          is_next;
  logic          sel_hit;
  logic [CB-1:0] cnt_sat;
  logic          wr_pat;
  logic          wr_cnt;
  logic [CB-1:0] cnt_wval;

  assign row_live = MY_USED < used_rows;
  assign is_next  = MY_USED == used_rows;
  assign sel_hit  = CMP_W'(sel_i) == MY_SEL;
  assign cnt_sat  = (count_r == {CB{1'b1}}) ? count_r : count_r + CB'(1);

  always_comb begin
    ctrl_nxt = ctrl_i;
    row_nxt  = row_i;
    rpat_nxt = rpat_i;
    rcnt_nxt = rcnt_i;
    wr_pat   = 1'b0;
    wr_cnt   = 1'b0;
    cnt_wval = cnt_sat;
    if (ctrl_i.valid && !ctrl_i.hit) begin
      unique case (ctrl_i.op)
        dpc_pkg::OP_COUNT: begin
          // rows are distinct, so at most one live row matches
          priority if (row_live && pattern_r == pat_i) begin
            ctrl_nxt.hit = 1'b1;
            row_nxt      = MY_ROW;
            rpat_nxt     = pattern_r;
            rcnt_nxt     = cnt_sat;
            wr_cnt       = 1'b1;
          end else if (is_next) begin
            // first free row: append
            ctrl_nxt.hit    = 1'b1;
            ctrl_nxt.is_new = 1'b1;
            row_nxt         = MY_ROW;
            rpat_nxt        = pat_i;
            rcnt_nxt        = CB'(1);
            cnt_wval        = CB'(1);
            wr_pat          = 1'b1;
            wr_cnt          = 1'b1;
          end else begin
          end
        end
        dpc_pkg::OP_READ: begin
          if (row_live && sel_hit) begin
            ctrl_nxt.hit = 1'b1;
            row_nxt      = MY_ROW;
            rpat_nxt     = pattern_r;
            rcnt_nxt     = count_r;
          end
        end
        dpc_pkg::OP_CLEAR, dpc_pkg::OP_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pat_r  <= pat_i;
      sel_r  <= sel_i;
      row_r  <= row_nxt;
      rpat_r <= rpat_nxt;
      rcnt_r <= rcnt_nxt;
      if (wr_pat) begin
        pattern_r <= pat_i;
      end
      if (wr_cnt) begin
        count_r <= cnt_wval;
      end
    end
  end

  assign ctrl_o = ctrl_r;
  assign pat_o  = pat_r;
  assign sel_o  = sel_r;
  assign row_o  = row_r;
  assign rpat_o = rpat_r;
  assign rcnt_o = rcnt_r;

endmodule

`default_nettype wire

// ----- hw/rtl/distinct_pattern_counter.sv -----
// distinct_pattern_counter: table of distinct label patterns with occurrence counts
// depends on dpc_pkg, dpc_in_if, dpc_out_if and dpc_cell
`default_nettype none

// channel   dir  handshake    payload
// in_ch     in   valid/ready  kind, pattern, row_select
// out_ch    out  valid/ready  status, row_index, pattern_out, occurrences, rows_in_use
//
// an item's token walks the row chain one cell per cycle, then lands in the output
// register; no new item is accepted until it has landed there
// one item is in the chain at a time; in_ch.ready is high whenever the chain is empty
// a result waiting in the output register does not block the next accept; the chain
// only holds its last stage when that stage is done and the output is still full
// reset (synchronous, active low) empties the table and the chain; row contents
// are left as they are and only rows below the fill count are ever looked at

module distinct_pattern_counter #(
  parameter int TABLE_ROWS  = 64,
  parameter int PATTERN_LEN = 4,
  parameter int LABEL_BITS  = 8,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dpc_in_if.sink     in_ch,
  dpc_out_if.source  out_ch
);

  localparam int IW = $clog2(TABLE_ROWS);
  localparam int UW = $clog2(TABLE_ROWS+1);
  // only the low PATTERN_LEN*LABEL_BITS bits of a pattern, at most 32, ever take part
  localparam int SW = (PATTERN_LEN*LABEL_BITS >= dpc_pkg::PAT_W) ?
                      dpc_pkg::PAT_W : PATTERN_LEN*LABEL_BITS;
  localparam int CB = COUNT_BITS;

  // fill count and control
  logic [UW-1:0] used_r, used_nxt;
  logic          busy_r;
  logic          acc;
  logic          adv;
  logic          consume;

  // output register
  logic                           out_valid_r;
  logic [dpc_pkg::STAT_W-1:0]     status_r, status_nxt;
  logic [dpc_pkg::SEL_W-1:0]      row_index_r, row_index_nxt;
  logic [dpc_pkg::PAT_W-1:0]      pattern_out_r, pattern_out_nxt;
  logic [dpc_pkg::CNT_W-1:0]      occurrences_r, occurrences_nxt;
  logic [dpc_pkg::ROWS_W-1:0]     rows_in_use_r;

  // token chain taps: entry i feeds cell i, entry TABLE_ROWS is the chain end
  dpc_pkg::tok_ctrl_t          ctrl_c [TABLE_ROWS+1];
  logic [SW-1:0]               tpat_c [TABLE_ROWS+1];
  logic [dpc_pkg::SEL_W-1:0]   tsel_c [TABLE_ROWS+1];
  logic [IW-1:0]               trow_c [TABLE_ROWS+1];
  logic [SW-1:0]               trpat_c [TABLE_ROWS+1];
  logic [CB-1:0]               trcnt_c [TABLE_ROWS+1];
  logic [TABLE_ROWS-1:0]       chain_vld;

  dpc_pkg::tok_ctrl_t end_ctrl;

  assign in_ch.ready = !busy_r;
  assign acc         = in_ch.valid && !busy_r;

  assign end_ctrl = ctrl_c[TABLE_ROWS];
  // the finished transaction leaves the chain once the output register is free
  assign consume  = end_ctrl.valid && (!out_valid_r || out_ch.ready);
  assign adv      = !end_ctrl.valid || consume;

  // chain entry straight from the input channel
  always_comb begin
    ctrl_c[0].valid  = acc;
    ctrl_c[0].op     = dpc_pkg::op_t'(in_ch.kind);
    ctrl_c[0].hit    = 1'b0;
    ctrl_c[0].is_new = 1'b0;
  end
  assign tpat_c[0]  = in_ch.pattern[SW-1:0];
  assign tsel_c[0]  = in_ch.row_select;
  assign trow_c[0]  = '0;
  assign trpat_c[0] = '0;
  assign trcnt_c[0] = '0;

  // row cells
  for (genvar g = 0; g < TABLE_ROWS; g++) begin : g_cell
    dpc_cell #(
      .TABLE_ROWS (TABLE_ROWS),
      .CELL_IDX   (g),
      .SW         (SW),
      .CB         (CB)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .used_rows (used_r),
      .ctrl_i    (ctrl_c[g]),
      .pat_i     (tpat_c[g]),
      .sel_i     (tsel_c[g]),
      .row_i     (trow_c[g]),
      .rpat_i    (trpat_c[g]),
      .rcnt_i    (trcnt_c[g]),
      .ctrl_o    (ctrl_c[g+1]),
      .pat_o     (tpat_c[g+1]),
      .sel_o     (tsel_c[g+1]),
      .row_o     (trow_c[g+1]),
      .rpat_o    (trpat_c[g+1]),
      .rcnt_o    (trcnt_c[g+1])
    );
    assign chain_vld[g] = ctrl_c[g+1].valid;
  end

  // turn the finished token into a result
  always_comb begin
    used_nxt        = used_r;
    status_nxt      = dpc_pkg::ST_BADIDX;
    row_index_nxt   = '0;
    pattern_out_nxt = '0;
    occurrences_nxt = '0;
    unique case (end_ctrl.op)
      dpc_pkg::OP_COUNT: begin
        if (end_ctrl.hit) begin
          status_nxt      = end_ctrl.is_new ? dpc_pkg::ST_NEW : dpc_pkg::ST_MATCH;
          row_index_nxt   = dpc_pkg::SEL_W'(trow_c[TABLE_ROWS]);
          pattern_out_nxt = dpc_pkg::PAT_W'(trpat_c[TABLE_ROWS]);
          occurrences_nxt = dpc_pkg::CNT_W'(trcnt_c[TABLE_ROWS]);
          if (end_ctrl.is_new) begin
            used_nxt = used_r + UW'(1);
          end
        end else begin
          // table full: pattern dropped
          status_nxt = dpc_pkg::ST_FULL;
        end
      end
      dpc_pkg::OP_READ: begin
        if (end_ctrl.hit) begin
          status_nxt      = dpc_pkg::ST_MATCH;
          row_index_nxt   = dpc_pkg::SEL_W'(trow_c[TABLE_ROWS]);
          pattern_out_nxt = dpc_pkg::PAT_W'(trpat_c[TABLE_ROWS]);
          occurrences_nxt = dpc_pkg::CNT_W'(trcnt_c[TABLE_ROWS]);
        end else begin
          // row beyond the fill count
          status_nxt    = dpc_pkg::ST_BADIDX;
          row_index_nxt = tsel_c[TABLE_ROWS];
        end
      end
      dpc_pkg::OP_CLEAR: begin
        status_nxt = dpc_pkg::ST_CLEARED;
        used_nxt   = '0;
      end
      dpc_pkg::OP_NONE: begin
        status_nxt = dpc_pkg::ST_BADIDX;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (consume) begin
        used_r      <= used_nxt;
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (acc) begin
          busy_r <= 1'b1;
        end
        if (out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (consume) begin
      status_r      <= status_nxt;
      row_index_r   <= row_index_nxt;
      pattern_out_r <= pattern_out_nxt;
      occurrences_r <= occurrences_nxt;
      rows_in_use_r <= dpc_pkg::ROWS_W'(used_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.row_index   = row_index_r;
  assign out_ch.pattern_out = pattern_out_r;
  assign out_ch.occurrences = occurrences_r;
  assign out_ch.rows_in_use = rows_in_use_r;

  // at most one token walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one token in the row chain");

  // an idle block has an empty chain
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> chain_vld == '0)
    else $error("token in the row chain while idle");

  // the fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ROWS))
    else $error("fill count beyond table size");

  // an accepted transaction enters the first cell on the next edge
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ctrl_c[1].valid && busy_r)
    else $error("accepted transaction missing from the first cell");

endmodule

`default_nettype wire

// ----- tb/tb_distinct_pattern_counter.sv -----
// tb_distinct_pattern_counter: self-checking testbench for the distinct pattern counter
// holds its own table model and compares every result transaction with it
// depends on dpc_pkg, dpc_in_if, dpc_out_if and the distinct_pattern_counter rtl
`timescale 1ns / 100ps

module tb_distinct_pattern_counter;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYC   = 11;
  localparam int TB_ROWS     = 64;
  localparam int TB_PAT_LEN  = 4;
  localparam int TB_LBL_BITS = 8;
  localparam int TB_CNT_BITS = 16;
  localparam int RAND_ITEMS  = 1000;
  // one pattern counted this many times in the directed part
  localparam int REPEAT_CNT  = 20;
  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT  = 2000;

  localparam int PAT_BITS = TB_PAT_LEN * TB_LBL_BITS;
  localparam logic [dpc_pkg::PAT_W-1:0] PAT_MASK =
    {dpc_pkg::PAT_W{1'b1}} >> (dpc_pkg::PAT_W - PAT_BITS);
  localparam logic [dpc_pkg::CNT_W-1:0] CNT_MAX =
    dpc_pkg::CNT_W'((1 << TB_CNT_BITS) - 1);

  // one input transaction
  typedef struct packed {
    dpc_pkg::op_t                 kind;
    logic [dpc_pkg::PAT_W-1:0]    pattern;
    logic [dpc_pkg::SEL_W-1:0]    row_select;
  } count_req_t;

  // one result transaction
  typedef struct packed {
    logic [dpc_pkg::STAT_W-1:0] status;
    logic [dpc_pkg::SEL_W-1:0]  row_index;
    logic [dpc_pkg::PAT_W-1:0]  pattern_out;
    logic [dpc_pkg::CNT_W-1:0]  occurrences;
    logic [dpc_pkg::ROWS_W-1:0] rows_in_use;
  } count_rsp_t;

  // stimulus entry; drain_first holds it back until every result is in
  typedef struct {
    count_req_t req;
    bit         drain_first;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst_n;

  dpc_in_if  in_ch ();
  dpc_out_if out_ch ();

  distinct_pattern_counter #(
    .TABLE_ROWS (TB_ROWS),
    .PATTERN_LEN(TB_PAT_LEN),
    .LABEL_BITS (TB_LBL_BITS),
    .COUNT_BITS (TB_CNT_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // table model: patterns and counts in order of first appearance
  logic [dpc_pkg::PAT_W-1:0] tbl_pattern [TB_ROWS];
  logic [dpc_pkg::CNT_W-1:0] tbl_count   [TB_ROWS];
  int                        tbl_rows;

  queued_req_t item_queue [$];
  count_rsp_t  due_results [$];

  int total_items;
  int items_in;
  int results_out;
  int results_owed;
  int errors;
  int status_hits [8];
  int saturated_hits;

  // idling state of both sides
  bit send_idle;
  bit recv_idle;
  int gap_left;
  int stall_left;
  bit just_taken;
  int quiet_cycles;

  // advance the table model by one accepted transaction, return its result
  function automatic count_rsp_t tally_step(count_req_t req);
    count_rsp_t                rsp;
    logic [dpc_pkg::PAT_W-1:0] key;
    int                        hit;
    rsp = '0;
    key = req.pattern & PAT_MASK;
    case (req.kind)
      dpc_pkg::OP_COUNT: begin
        hit = -1;
        for (int i = 0; i < tbl_rows; i++) begin
          if (hit < 0 && tbl_pattern[i] == key) hit = i;
        end
        if (hit >= 0) begin
          // count sticks at its maximum
          if (tbl_count[hit] < CNT_MAX) tbl_count[hit] = tbl_count[hit] + 1'b1;
          rsp.status      = dpc_pkg::ST_MATCH;
          rsp.row_index   = dpc_pkg::SEL_W'(hit);
          rsp.pattern_out = tbl_pattern[hit];
          rsp.occurrences = tbl_count[hit];
        end else if (tbl_rows < TB_ROWS) begin
          tbl_pattern[tbl_rows] = key;
          tbl_count[tbl_rows]   = dpc_pkg::CNT_W'(1);
          rsp.status      = dpc_pkg::ST_NEW;
          rsp.row_index   = dpc_pkg::SEL_W'(tbl_rows);
          rsp.pattern_out = key;
          rsp.occurrences = dpc_pkg::CNT_W'(1);
          tbl_rows++;
        end else begin
          // table full, pattern dropped
          rsp.status = dpc_pkg::ST_FULL;
        end
      end
      dpc_pkg::OP_READ: begin
        rsp.row_index = req.row_select;
        if (int'(req.row_select) < tbl_rows) begin
          rsp.status      = dpc_pkg::ST_MATCH;
          rsp.pattern_out = tbl_pattern[req.row_select];
          rsp.occurrences = tbl_count[req.row_select];
        end else begin
          rsp.status = dpc_pkg::ST_BADIDX;
        end
      end
      dpc_pkg::OP_CLEAR: begin
        tbl_rows   = 0;
        rsp.status = dpc_pkg::ST_CLEARED;
      end
      default: begin
        // unused kind is ignored
        rsp.status = dpc_pkg::ST_BADIDX;
      end
    endcase
    rsp.rows_in_use = dpc_pkg::ROWS_W'(tbl_rows);
    return rsp;
  endfunction

  task automatic queue_item(input dpc_pkg::op_t op, input logic [dpc_pkg::PAT_W-1:0] pat,
                            input logic [dpc_pkg::SEL_W-1:0] sel, input bit drain);
    queued_req_t q;
    q.req.kind       = op;
    q.req.pattern    = pat;
    q.req.row_select = sel;
    q.drain_first    = drain;
    item_queue.push_back(q);
    total_items++;
  endtask

  // driver: presents queued items, random gap after an accepted transaction while send_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      just_taken = in_ch.valid && in_ch.ready;
      if (just_taken) begin
        gap_left = send_idle ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
      end
      if (in_ch.valid && !just_taken) begin
        // item still waiting for ready, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (item_queue.size() == 0 ||
                   (item_queue[0].drain_first && (just_taken || results_owed != 0))) begin
        // nothing left, or pausing until the block has delivered everything
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= item_queue[0].req.kind;
        in_ch.pattern    <= item_queue[0].req.pattern;
        in_ch.row_select <= item_queue[0].req.row_select;
        void'(item_queue.pop_front());
      end
    end
  end

  // monitor: predicts on every input transaction, checks every result transaction
  always @(posedge clk) begin
    count_req_t got_req;
    count_rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      results_owed <= 0;
      stall_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        got_req.kind       = dpc_pkg::op_t'(in_ch.kind);
        got_req.pattern    = in_ch.pattern;
        got_req.row_select = in_ch.row_select;
        due_results.push_back(tally_step(got_req));
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no transaction outstanding: status %0d row %0d",
                 out_ch.status, out_ch.row_index);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, out_ch.row_index);
            errors++;
          end
          if (out_ch.pattern_out !== want.pattern_out) begin
            $error("pattern_out: expected %h, got %h", want.pattern_out,
                   out_ch.pattern_out);
            errors++;
          end
          if (out_ch.occurrences !== want.occurrences) begin
            $error("occurrences: expected %0d, got %0d", want.occurrences,
                   out_ch.occurrences);
            errors++;
          end
          if (out_ch.rows_in_use !== want.rows_in_use) begin
            $error("rows_in_use: expected %0d, got %0d", want.rows_in_use,
                   out_ch.rows_in_use);
            errors++;
          end
          status_hits[want.status]++;
          if (want.status == dpc_pkg::ST_MATCH && want.occurrences == CNT_MAX) begin
            saturated_hits++;
          end
        end
        results_out++;
        stall_left = recv_idle ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      end else if (out_ch.valid && stall_left > 0) begin
        // result sits in the output register while we stall
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
      results_owed <= due_results.size();
    end
  end

  // watchdog: ends the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("hang: no transaction for %0d cycles, %0d of %0d items in, %0d results",
               HANG_LIMIT, items_in, total_items, results_out);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [dpc_pkg::PAT_W-1:0] pool [$];
    int                        pool_size;
    int                        run_len;
    int                        run_no;
    int                        rand_items;
    int                        pick;
    bit                        big;

    // every input known from time zero
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = dpc_pkg::OP_COUNT;
    in_ch.pattern    = '0;
    in_ch.row_select = '0;
    out_ch.ready     = 1'b0;
    tbl_rows         = 0;
    send_idle        = 1'b1;
    recv_idle        = 1'b1;
    run_no           = 0;
    rand_items       = 0;

    // directed part
    // read on an empty table
    queue_item(dpc_pkg::OP_READ, dpc_pkg::PAT_W'($urandom), dpc_pkg::SEL_W'(0), 1'b0);
    // pattern extremes as new rows, then a match
    queue_item(dpc_pkg::OP_COUNT, '0, dpc_pkg::SEL_W'($urandom), 1'b0);
    queue_item(dpc_pkg::OP_COUNT, '1, dpc_pkg::SEL_W'($urandom), 1'b0);
    queue_item(dpc_pkg::OP_COUNT, '0, '1, 1'b0);
    // read a stored row, read past the fill count at the top index
    queue_item(dpc_pkg::OP_READ, '1, dpc_pkg::SEL_W'(1), 1'b0);
    queue_item(dpc_pkg::OP_READ, '0, '1, 1'b0);
    // unused kind is ignored
    queue_item(dpc_pkg::OP_NONE, '1, '1, 1'b0);
    // one pattern counted over and over
    repeat (REPEAT_CNT) begin
      queue_item(dpc_pkg::OP_COUNT, 32'hA5A5_5A5A, dpc_pkg::SEL_W'($urandom), 1'b0);
    end
    // clear once the block has gone quiet, then a read of a stale row
    queue_item(dpc_pkg::OP_CLEAR, '1, '1, 1'b1);
    queue_item(dpc_pkg::OP_READ, dpc_pkg::PAT_W'($urandom), dpc_pkg::SEL_W'(0), 1'b0);

    // random part: runs that start with a clear and mostly count patterns from a pool
    // small pools give long counts, large pools overflow the table
    while (rand_items < RAND_ITEMS) begin
      big       = (run_no == 0) || ($urandom_range(0, 3) == 0);
      pool_size = (run_no == 0) ? 96 : (big ? $urandom_range(70, 100) : $urandom_range(1, 12));
      run_len   = (run_no == 0) ? 220 : (big ? $urandom_range(150, 250) : $urandom_range(20, 60));
      pool.delete();
      repeat (pool_size) pool.push_back(dpc_pkg::PAT_W'($urandom));
      queue_item(dpc_pkg::OP_CLEAR, dpc_pkg::PAT_W'($urandom), dpc_pkg::SEL_W'($urandom),
                 $urandom_range(0, 2) == 0);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          queue_item(dpc_pkg::OP_COUNT, pool[$urandom_range(0, pool_size - 1)],
                     dpc_pkg::SEL_W'($urandom), 1'b0);
        end else if (pick < 80) begin
          queue_item(dpc_pkg::OP_READ, dpc_pkg::PAT_W'($urandom),
                     dpc_pkg::SEL_W'($urandom_range(0, 15)), 1'b0);
        end else if (pick < 88) begin
          queue_item(dpc_pkg::OP_READ, dpc_pkg::PAT_W'($urandom),
                     dpc_pkg::SEL_W'($urandom), 1'b0);
        end else if (pick < 94) begin
          queue_item(dpc_pkg::OP_COUNT, dpc_pkg::PAT_W'($urandom),
                     dpc_pkg::SEL_W'($urandom), 1'b0);
        end else if (pick < 97) begin
          queue_item(dpc_pkg::OP_NONE, dpc_pkg::PAT_W'($urandom),
                     dpc_pkg::SEL_W'($urandom), 1'b0);
        end else begin
          // stray clear in the middle of a run
          queue_item(dpc_pkg::OP_CLEAR, dpc_pkg::PAT_W'($urandom),
                     dpc_pkg::SEL_W'($urandom), $urandom_range(0, 1) == 1);
        end
      end
      rand_items += run_len + 1;
      run_no++;
    end

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to go in and every result to come out, then linger
    while (items_in != total_items || due_results.size() != 0) @(negedge clk);
    repeat (2 * TB_ROWS + 8) @(posedge clk);

    $display("%0d transactions in %0d runs: %0d match/read, %0d new, %0d full, %0d bad index,",
             items_in, run_no, status_hits[dpc_pkg::ST_MATCH], status_hits[dpc_pkg::ST_NEW],
             status_hits[dpc_pkg::ST_FULL], status_hits[dpc_pkg::ST_BADIDX]);
    $display("%0d clears, %0d results at the count limit, %0d mismatches",
             status_hits[dpc_pkg::ST_CLEARED], saturated_hits, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
